// ===== rtl/life_pattern_text_to_cells_top_macros.svh =====
// assertion macros for the life pattern decoder checker
`ifndef LIFE_PATTERN_TEXT_TO_CELLS_TOP_MACROS_SVH
`define LIFE_PATTERN_TEXT_TO_CELLS_TOP_MACROS_SVH

// property checked at every rising clk_i edge outside reset
`define LPTC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// consequent checked in the cycle after the antecedent
`define LPTC_ASSERT_NEXT(label, ante, cons, msg) \
  `LPTC_ASSERT(label, (ante) |=> (cons), msg)

`endif

// ===== rtl/lptc_pkg.sv =====
// shared types and constants of the life pattern decoder
package lptc_pkg;

  localparam int unsigned CoordBitsDef = 16;
  localparam int unsigned QueueDepth   = 2;
  localparam int unsigned CellW        = 16;
  localparam int unsigned KindW        = 2;
  localparam int unsigned CfgIdxW      = 3;
  localparam int unsigned CfgDataW     = 16;
  localparam int unsigned TabStep      = 8;

  localparam logic [7:0] ChrStar  = 8'h2A;
  localparam logic [7:0] ChrTab   = 8'h09;
  localparam logic [7:0] ChrNl    = 8'h0A;
  localparam logic [7:0] ChrCr    = 8'h0D;
  localparam logic [7:0] ChrSpace = 8'h20;
  localparam logic [7:0] ChrHash  = 8'h23;
  localparam logic [7:0] ChrPlus  = 8'h2B;
  localparam logic [7:0] ChrMinus = 8'h2D;
  localparam logic [7:0] ChrZero  = 8'h30;
  localparam logic [7:0] ChrNine  = 8'h39;
  localparam logic [7:0] ChrA     = 8'h41;
  localparam logic [7:0] ChrB     = 8'h42;
  localparam logic [7:0] ChrE     = 8'h45;
  localparam logic [7:0] ChrP     = 8'h50;
  localparam logic [7:0] ChrR     = 8'h52;

  localparam logic [1:0] GainPos    = 2'b01;
  localparam logic [1:0] GainNegTwo = 2'b10;
  localparam logic [1:0] GainNeg    = 2'b11;

  typedef enum logic [KindW-1:0] {
    KindCell  = 2'd0,
    KindEnd   = 2'd1,
    KindError = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    PhStart,
    PhHash,
    PhDirective,
    PhBody,
    PhSkipStart,
    PhSkipHash,
    PhSkipRest,
    PhSkipClose
  } phase_e;

  typedef enum logic [1:0] {
    HdrNone,
    HdrB,
    HdrP,
    HdrR
  } hdr_e;

  typedef enum logic [1:0] {
    DsIdle,
    DsSign,
    DsDigits
  } dstage_e;

  typedef enum logic [CfgIdxW-1:0] {
    RegHotX  = 3'd0,
    RegHotY  = 3'd1,
    RegMatXx = 3'd2,
    RegMatXy = 3'd3,
    RegMatYx = 3'd4,
    RegMatYy = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic [15:0] hot_x;
    logic [15:0] hot_y;
    logic [1:0]  mat_xx;
    logic [1:0]  mat_xy;
    logic [1:0]  mat_yx;
    logic [1:0]  mat_yy;
  } cfg_t;

  localparam cfg_t CfgReset = '{
    hot_x:  16'd32768,
    hot_y:  16'd32768,
    mat_xx: GainPos,
    mat_xy: 2'b00,
    mat_yx: 2'b00,
    mat_yy: GainPos
  };

endpackage

// ===== rtl/lptc_fifo.sv =====
// small queue between the parser front and the placement back
module lptc_fifo #(
  parameter int unsigned Width = 34,
  parameter int unsigned Depth = lptc_pkg::QueueDepth
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] push_data_i,
  input  logic             pop_i,
  output logic             full_o,
  output logic             valid_o,
  output logic [Width-1:0] data_o
);
  import lptc_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;
  logic             do_pop;

  assign full_o  = (count_q == CntW'(Depth));
  assign valid_o = (count_q != '0);
  assign data_o  = mem_q[rd_ptr_q];
  assign do_pop  = pop_i & valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (push_i && !do_pop) begin
      count_d = count_q + CntW'(1);
    end else if (!push_i && do_pop) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// ===== rtl/lptc_front.sv =====
// byte parser: line phases, number scanner, counters and cell events
module lptc_front #(
  parameter int unsigned CoordBits = lptc_pkg::CoordBitsDef
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  logic [7:0]            in_byte_i,
  input  logic                  in_sof_i,
  input  logic                  q_full_i,
  output logic                  in_ready_o,
  output logic                  push_o,
  output lptc_pkg::kind_e       push_kind_o,
  output logic [CoordBits-1:0]  push_px_o,
  output logic [CoordBits-1:0]  push_py_o
);
  import lptc_pkg::*;

  typedef logic [CoordBits-1:0] coord_t;

  logic    acc, ev, do_body, do_lreset;
  logic    rel_q, rel_b, rel_d;
  phase_e  ph_q, ph_b, ph_d;
  hdr_e    hdr_q, hdr_b, hdr_d;
  coord_t  xo_q, xo_b, xo_d, yo_q, yo_b, yo_d;
  coord_t  row_q, row_b, row_d, col_q, col_b, col_d;
  coord_t  nval_q, nval_b, nval_d, first_q, first_b, first_d;
  logic    nneg_q, nneg_b, nneg_d, notnum_q, notnum_b, notnum_d;
  logic    fin_q, fin_b, fin_d;
  logic [1:0] npar_q, npar_b, npar_d;
  dstage_e ds_q, ds_b, ds_d;

  logic       digit, blank;
  logic [3:0] dval;
  coord_t     nf_nval, nf_first, nf_val;
  logic       nf_nneg, nf_notnum, nf_one, nf_two, nf_go;
  logic [1:0] nf_npar;
  dstage_e    nf_ds;
  kind_e      ev_kind;
  coord_t     ev_px, ev_py;

  assign acc        = in_valid_i & ~q_full_i;
  assign in_ready_o = ~q_full_i;
  assign push_o     = acc & ev;
  assign push_kind_o = ev_kind;
  assign push_px_o  = ev_px;
  assign push_py_o  = ev_py;

  // start of file clears state ahead of the byte
  always_comb begin
    rel_b = rel_q; ph_b = ph_q; hdr_b = hdr_q; xo_b = xo_q; yo_b = yo_q;
    row_b = row_q; col_b = col_q; nval_b = nval_q; first_b = first_q;
    nneg_b = nneg_q; notnum_b = notnum_q; fin_b = fin_q; npar_b = npar_q; ds_b = ds_q;
    if (in_sof_i) begin
      rel_b = 1'b0; ph_b = PhStart; hdr_b = HdrNone; xo_b = '0; yo_b = '0;
      row_b = '0; col_b = '0; nval_b = '0; first_b = '0;
      nneg_b = 1'b0; notnum_b = 1'b0; fin_b = 1'b0; npar_b = '0; ds_b = DsIdle;
    end
  end

  assign digit = (in_byte_i >= ChrZero) && (in_byte_i <= ChrNine);
  assign dval  = 4'(in_byte_i - ChrZero);
  assign blank = (in_byte_i == ChrSpace) || ((in_byte_i >= ChrTab) && (in_byte_i <= ChrCr));

  // number scanner
  always_comb begin
    nf_nval = nval_b; nf_first = first_b; nf_nneg = nneg_b; nf_notnum = notnum_b;
    nf_npar = npar_b; nf_ds = ds_b;
    nf_val = '0; nf_one = 1'b0; nf_two = 1'b0; nf_go = 1'b1;
    if (!notnum_b && (npar_b < 2'd2)) begin
      if (ds_b == DsDigits) begin
        if (digit) begin
          nf_nval = (nval_b << 3) + (nval_b << 1) + CoordBits'(dval);
          nf_go   = 1'b0;
        end else begin
          nf_val  = nneg_b ? -nval_b : nval_b;
          nf_npar = npar_b + 2'd1;
          nf_ds   = DsIdle;
          nf_nneg = 1'b0;
          nf_nval = '0;
          if (nf_npar == 2'd2) begin
            nf_two = 1'b1;
            nf_go  = 1'b0;
          end else begin
            nf_first = nf_val;
            nf_one   = 1'b1;
          end
        end
      end
      if (nf_go) begin
        if (digit) begin
          nf_nval = CoordBits'(dval);
          nf_ds   = DsDigits;
        end else if (nf_ds == DsIdle && blank) begin
          nf_ds = DsIdle;
        end else if (nf_ds == DsIdle && (in_byte_i == ChrPlus || in_byte_i == ChrMinus)) begin
          nf_nneg = (in_byte_i == ChrMinus);
          nf_ds   = DsSign;
        end else begin
          nf_notnum = 1'b1;
        end
      end
    end
  end

  // line phase machine
  always_comb begin
    rel_d = rel_b; ph_d = ph_b; hdr_d = hdr_b; xo_d = xo_b; yo_d = yo_b;
    row_d = row_b; col_d = col_b; nval_d = nval_b; first_d = first_b;
    nneg_d = nneg_b; notnum_d = notnum_b; fin_d = fin_b; npar_d = npar_b; ds_d = ds_b;
    do_body = 1'b0;
    do_lreset = 1'b0;
    if (!fin_b) begin
      unique case (ph_b)
        PhStart: begin
          if (in_byte_i == ChrHash) begin
            ph_d = PhHash;
          end else if (in_byte_i == ChrNl) begin
            row_d = row_b + CoordBits'(1);
            do_lreset = 1'b1;
          end else begin
            ph_d = PhBody;
            do_body = 1'b1;
          end
        end
        PhBody: begin
          do_body = 1'b1;
        end
        PhHash: begin
          if (in_byte_i == ChrNl) begin
            row_d = row_b + CoordBits'(1);
            do_lreset = 1'b1;
            ph_d = PhStart;
          end else if (in_byte_i == ChrE || in_byte_i == ChrA) begin
            fin_d = 1'b1;
          end else begin
            if (in_byte_i == ChrB) begin
              hdr_d = HdrB;
            end else if (in_byte_i == ChrP) begin
              hdr_d = HdrP;
            end else if (in_byte_i == ChrR) begin
              hdr_d = HdrR;
            end else begin
              hdr_d = HdrNone;
            end
            if (in_byte_i == ChrP || in_byte_i == ChrR) begin
              rel_d = (in_byte_i == ChrR);
              xo_d  = '0;
              yo_d  = '0;
              if (in_byte_i == ChrP) begin
                row_d = '0;
              end
            end
            ph_d = PhDirective;
          end
        end
        PhDirective: begin
          if (hdr_b == HdrP || hdr_b == HdrR) begin
            nval_d = nf_nval; first_d = nf_first; nneg_d = nf_nneg;
            notnum_d = nf_notnum; npar_d = nf_npar; ds_d = nf_ds;
            if (nf_one) begin
              xo_d = nf_val;
            end else if (nf_two) begin
              yo_d = nf_val;
            end
          end
          if (in_byte_i == ChrNl) begin
            if (hdr_b == HdrB) begin
              ph_d = PhSkipStart;
            end else begin
              row_d = row_b + CoordBits'(1);
              ph_d = PhStart;
            end
            hdr_d = HdrNone;
            do_lreset = 1'b1;
          end
        end
        PhSkipStart: begin
          if (in_byte_i == ChrHash) begin
            ph_d = PhSkipHash;
          end else if (in_byte_i != ChrNl) begin
            ph_d = PhSkipRest;
          end
        end
        PhSkipHash: begin
          if (in_byte_i == ChrE) begin
            ph_d = PhSkipClose;
          end else if (in_byte_i == ChrNl) begin
            ph_d = PhSkipStart;
          end else begin
            ph_d = PhSkipRest;
          end
        end
        PhSkipRest: begin
          if (in_byte_i == ChrNl) begin
            ph_d = PhSkipStart;
          end
        end
        PhSkipClose: begin
          if (in_byte_i == ChrNl) begin
            row_d = row_b + CoordBits'(1);
            do_lreset = 1'b1;
            ph_d = PhStart;
          end
        end
        default: begin
          ph_d = PhStart;
        end
      endcase
    end
    if (do_body) begin
      if (rel_b) begin
        nval_d = nf_nval; first_d = nf_first; nneg_d = nf_nneg;
        notnum_d = nf_notnum; npar_d = nf_npar; ds_d = nf_ds;
      end
      if (in_byte_i == ChrNl) begin
        row_d = row_b + CoordBits'(1);
        do_lreset = 1'b1;
        ph_d = PhStart;
      end else if (in_byte_i == ChrTab) begin
        col_d = (col_b + CoordBits'(TabStep)) & ~CoordBits'(TabStep - 1);
      end else begin
        col_d = col_b + CoordBits'(1);
      end
    end
    if (do_lreset) begin
      col_d = '0; nval_d = '0; nneg_d = 1'b0; npar_d = '0;
      first_d = '0; notnum_d = 1'b0; ds_d = DsIdle;
    end
  end

  // event towards the back
  always_comb begin
    ev = 1'b0;
    ev_kind = KindCell;
    ev_px = '0;
    ev_py = '0;
    if (!fin_b) begin
      if (ph_b == PhHash && in_byte_i == ChrE) begin
        ev = 1'b1;
        ev_kind = KindEnd;
      end else if (ph_b == PhHash && in_byte_i == ChrA) begin
        ev = 1'b1;
        ev_kind = KindError;
      end else if (do_body && rel_b && nf_two) begin
        ev = 1'b1;
        ev_px = xo_b + nf_first;
        ev_py = yo_b + nf_val;
      end else if (do_body && in_byte_i == ChrStar && (!rel_b || nf_notnum)) begin
        ev = 1'b1;
        ev_px = xo_b + col_b;
        ev_py = yo_b + row_b;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rel_q <= 1'b0; ph_q <= PhStart; hdr_q <= HdrNone; xo_q <= '0; yo_q <= '0;
      row_q <= '0; col_q <= '0; nval_q <= '0; first_q <= '0;
      nneg_q <= 1'b0; notnum_q <= 1'b0; fin_q <= 1'b0; npar_q <= '0; ds_q <= DsIdle;
    end else if (acc) begin
      rel_q <= rel_d; ph_q <= ph_d; hdr_q <= hdr_d; xo_q <= xo_d; yo_q <= yo_d;
      row_q <= row_d; col_q <= col_d; nval_q <= nval_d; first_q <= first_d;
      nneg_q <= nneg_d; notnum_q <= notnum_d; fin_q <= fin_d; npar_q <= npar_d; ds_q <= ds_d;
    end
  end

endmodule

// ===== rtl/lptc_back.sv =====
// placement: gain matrix (+1, -1, -2 or 0) and hot point applied, output register
module lptc_back #(
  parameter int unsigned CoordBits = lptc_pkg::CoordBitsDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  lptc_pkg::cfg_t       cfg_i,
  input  logic                 q_valid_i,
  input  lptc_pkg::kind_e      q_kind_i,
  input  logic [CoordBits-1:0] q_px_i,
  input  logic [CoordBits-1:0] q_py_i,
  output logic                 pop_o,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [2*lptc_pkg::CellW-1:0] m_axis_tdata,
  output logic [lptc_pkg::KindW-1:0]   m_axis_tuser
);
  import lptc_pkg::*;

  localparam int unsigned ExtW = (CoordBits > CellW) ? CoordBits : CellW;

  typedef logic [CoordBits-1:0] coord_t;

  function automatic coord_t gain(input logic [1:0] g, input coord_t v);
    coord_t r;
    case (g)
      GainPos:    r = v;
      GainNegTwo: r = -(v << 1);
      GainNeg:    r = -v;
      default:    r = '0;
    endcase
    return r;
  endfunction

  coord_t             wx, wy;
  logic [ExtW-1:0]    wx_ext, wy_ext;
  logic               vld_q, vld_d;
  logic [CellW-1:0]   x_q, x_d, y_q, y_d;
  logic [KindW-1:0]   kind_q, kind_d;

  assign wx = CoordBits'(cfg_i.hot_x) + gain(cfg_i.mat_xx, q_px_i) + gain(cfg_i.mat_xy, q_py_i);
  assign wy = CoordBits'(cfg_i.hot_y) + gain(cfg_i.mat_yx, q_px_i) + gain(cfg_i.mat_yy, q_py_i);
  assign wx_ext = ExtW'(wx);
  assign wy_ext = ExtW'(wy);

  assign pop_o = q_valid_i & (~vld_q | m_axis_tready);

  always_comb begin
    vld_d  = vld_q & ~m_axis_tready;
    x_d    = x_q;
    y_d    = y_q;
    kind_d = kind_q;
    if (pop_o) begin
      vld_d  = 1'b1;
      kind_d = q_kind_i;
      x_d    = (q_kind_i == KindCell) ? wx_ext[CellW-1:0] : '0;
      y_d    = (q_kind_i == KindCell) ? wy_ext[CellW-1:0] : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q    <= x_d;
    y_q    <= y_d;
    kind_q <= kind_d;
  end

  assign m_axis_tvalid = vld_q;
  assign m_axis_tdata  = {y_q, x_q};
  assign m_axis_tuser  = kind_q;

endmodule

// ===== rtl/life_pattern_text_to_cells_top.sv =====
// top level of the life pattern text decoder
//
// channel  direction  handshake              payload
// s_axis   in         tvalid / tready        tdata text_byte, tuser start_of_file
// m_axis   out        tvalid / tready        tdata cell_x, cell_y; tuser result_kind
// cfg      in         cfg_we_i (no wait)     cfg_idx_i register, cfg_data_i value
//
// one byte per cycle while s_axis_tready is high; the parser updates its state
// in the cycle it accepts the byte; a result reaches m_axis through a two-entry
// queue and the output register of the placement stage
// s_axis_tready drops only when the queue is full behind a stalled output
// reset clears all parse state and loads the default hot point and identity matrix
module life_pattern_text_to_cells_top #(
  parameter int unsigned CoordBits = lptc_pkg::CoordBitsDef
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [7:0]                        s_axis_tdata,  // text_byte
  input  logic                              s_axis_tuser,  // start_of_file
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [2*lptc_pkg::CellW-1:0]      m_axis_tdata,  // cell_x, cell_y
  output logic [lptc_pkg::KindW-1:0]        m_axis_tuser,  // result_kind
  input  logic                              cfg_we_i,
  input  logic [lptc_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  logic [lptc_pkg::CfgDataW-1:0]     cfg_data_i
);
  import lptc_pkg::*;

  localparam int unsigned EntryW = KindW + 2 * CoordBits;

  cfg_t                 cfg_q, cfg_d;
  logic                 q_full, q_valid, push, pop;
  kind_e                push_kind;
  logic [CoordBits-1:0] push_px, push_py;
  logic [EntryW-1:0]    q_wdata, q_rdata;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        RegHotX:  cfg_d.hot_x  = cfg_data_i;
        RegHotY:  cfg_d.hot_y  = cfg_data_i;
        RegMatXx: cfg_d.mat_xx = cfg_data_i[1:0];
        RegMatXy: cfg_d.mat_xy = cfg_data_i[1:0];
        RegMatYx: cfg_d.mat_yx = cfg_data_i[1:0];
        RegMatYy: cfg_d.mat_yy = cfg_data_i[1:0];
        default:  cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CfgReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  lptc_front #(
    .CoordBits (CoordBits)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_byte_i   (s_axis_tdata),
    .in_sof_i    (s_axis_tuser),
    .q_full_i    (q_full),
    .in_ready_o  (s_axis_tready),
    .push_o      (push),
    .push_kind_o (push_kind),
    .push_px_o   (push_px),
    .push_py_o   (push_py)
  );

  assign q_wdata = {push_kind, push_py, push_px};

  lptc_fifo #(
    .Width (EntryW),
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (q_wdata),
    .pop_i       (pop),
    .full_o      (q_full),
    .valid_o     (q_valid),
    .data_o      (q_rdata)
  );

  lptc_back #(
    .CoordBits (CoordBits)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .q_valid_i     (q_valid),
    .q_kind_i      (kind_e'(q_rdata[EntryW-1 -: KindW])),
    .q_px_i        (q_rdata[CoordBits-1:0]),
    .q_py_i        (q_rdata[2*CoordBits-1:CoordBits]),
    .pop_o         (pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

endmodule

// ===== rtl/lptc_checker.sv =====
// port checker for the life pattern decoder, bound to the top level
`include "life_pattern_text_to_cells_top_macros.svh"

module lptc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata,
  input logic [1:0]  m_axis_tuser
);
  import lptc_pkg::*;

  `LPTC_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "stalled result changed")
  `LPTC_ASSERT(a_kind_legal, m_axis_tvalid |-> (m_axis_tuser == KindCell || m_axis_tuser == KindEnd || m_axis_tuser == KindError), "undefined result kind")
  `LPTC_ASSERT(a_flag_zero, (m_axis_tvalid && m_axis_tuser != KindCell) |-> (m_axis_tdata == '0), "end or error transfer with coordinates")
  `LPTC_ASSERT(a_stall_cause, !s_axis_tready |-> m_axis_tvalid, "input stalled with no result waiting")

endmodule

bind life_pattern_text_to_cells_top lptc_checker u_lptc_checker (.*);

// ===== tb/sv/life_pattern_text_to_cells_top_tb.sv =====
// self-checking testbench of the life pattern text decoder, with its own decoder model
module life_pattern_text_to_cells_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import lptc_pkg::*;

  localparam int unsigned RandomBytes  = 1050;
  localparam int unsigned CycleLimit   = 400000;
  localparam int unsigned SettleCycles = 6;
  localparam int unsigned HoldCycles   = 64;
  localparam int unsigned MaxReported  = 10;

  typedef struct packed {
    kind_e       kind;
    logic [15:0] x;
    logic [15:0] y;
  } cell_result_t;

  typedef struct packed {
    logic [7:0]  text;
    logic        sof;
    logic        typed;
    kind_e       kind;
    logic [15:0] x;
    logic [15:0] y;
  } directed_row_t;

  localparam directed_row_t DirectedRows [23] = '{
    '{ChrHash, 1'b1, 1'b0, KindCell, 16'd0, 16'd0},
    '{ChrA, 1'b0, 1'b1, KindError, 16'd0, 16'd0},
    '{ChrStar, 1'b0, 1'b0, KindCell, 16'd0, 16'd0},
    '{ChrStar, 1'b1, 1'b1, KindCell, 16'd32768, 16'd32768},
    '{8'h00, 1'b0, 1'b0, KindCell, 16'd0, 16'd0},
    '{ChrTab, 1'b0, 1'b0, KindCell, 16'd0, 16'd0},
    '{ChrStar, 1'b0, 1'b1, KindCell, 16'd32776, 16'd32768},
    '{8'hFF, 1'b0, 1'b0, KindCell, 16'd0, 16'd0},
    '{ChrNl, 1'b0, 1'b0, KindCell, 16'd0, 16'd0},
    '{ChrHash, 1'b0, 1'b0, KindCell, 16'd0, 16'd0},
    '{ChrR, 1'b0, 1'b0, KindCell, 16'd0, 16'd0},
    '{ChrSpace, 1'b0, 1'b0, KindCell, 16'd0, 16'd0},
    '{ChrMinus, 1'b0, 1'b0, KindCell, 16'd0, 16'd0},
    '{ChrZero + 8'd3, 1'b0, 1'b0, KindCell, 16'd0, 16'd0},
    '{ChrSpace, 1'b0, 1'b0, KindCell, 16'd0, 16'd0},
    '{ChrZero + 8'd2, 1'b0, 1'b0, KindCell, 16'd0, 16'd0},
    '{ChrNl, 1'b0, 1'b0, KindCell, 16'd0, 16'd0},
    '{ChrZero + 8'd1, 1'b0, 1'b0, KindCell, 16'd0, 16'd0},
    '{ChrSpace, 1'b0, 1'b0, KindCell, 16'd0, 16'd0},
    '{ChrZero + 8'd4, 1'b0, 1'b0, KindCell, 16'd0, 16'd0},
    '{ChrNl, 1'b0, 1'b0, KindCell, 16'd0, 16'd0},
    '{ChrHash, 1'b0, 1'b0, KindCell, 16'd0, 16'd0},
    '{ChrE, 1'b0, 1'b1, KindEnd, 16'd0, 16'd0}
  };

  logic                   clk_i;
  logic                   rst_ni;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [7:0]             s_axis_tdata;
  logic                   s_axis_tuser;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  logic [2*CellW-1:0]     m_axis_tdata;
  logic [KindW-1:0]       m_axis_tuser;
  logic                   cfg_we_i;
  logic [CfgIdxW-1:0]     cfg_idx_i;
  logic [CfgDataW-1:0]    cfg_data_i;

  life_pattern_text_to_cells_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  // decoder model state
  cfg_t        placement;
  logic        rel_mode;
  phase_e      phase;
  hdr_e        hdr;
  logic [15:0] x_off;
  logic [15:0] y_off;
  logic [15:0] row_cnt;
  logic [15:0] col_cnt;
  logic [15:0] num_val;
  logic        num_neg;
  logic [1:0]  num_cnt;
  logic [15:0] first_num;
  logic        not_numeric;
  logic        done;
  dstage_e     dstage;

  cell_result_t expected_cells[$];
  logic [7:0]   file_text[$];
  int           cells_from_byte;
  logic         byte_ignored;
  int           bytes_decoded;
  int           mismatches;
  int           burst_left;
  logic         gapless;
  logic         pressure_go;
  logic         pressure_done;
  int unsigned  cycle_count;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("FAIL");
      $finish;
    end
  end

  task automatic clear_line();
    col_cnt     = '0;
    num_val     = '0;
    num_neg     = 1'b0;
    num_cnt     = '0;
    first_num   = '0;
    not_numeric = 1'b0;
    dstage      = DsIdle;
  endtask

  task automatic clear_parse();
    rel_mode = 1'b0;
    phase    = PhStart;
    hdr      = HdrNone;
    x_off    = '0;
    y_off    = '0;
    row_cnt  = '0;
    done     = 1'b0;
    clear_line();
  endtask

  function automatic logic [15:0] scale_by_gain(input logic [1:0] g, input logic [15:0] v);
    case (g)
      GainPos:    return v;
      GainNegTwo: return -(v << 1);
      GainNeg:    return -v;
      default:    return '0;
    endcase
  endfunction

  task automatic push_result(input kind_e kind, input logic [15:0] x, input logic [15:0] y);
    expected_cells.push_back('{kind, x, y});
    cells_from_byte++;
  endtask

  task automatic place_cell(input logic [15:0] px, input logic [15:0] py);
    logic [15:0] wx;
    logic [15:0] wy;
    wx = placement.hot_x + scale_by_gain(placement.mat_xx, px)
         + scale_by_gain(placement.mat_xy, py);
    wy = placement.hot_y + scale_by_gain(placement.mat_yx, px)
         + scale_by_gain(placement.mat_yy, py);
    push_result(KindCell, wx, wy);
  endtask

  // 1 when the first number of a line completes, 2 when the second does
  function automatic int scan_number(input logic [7:0] c, output logic [15:0] val);
    int   ret;
    logic digit;
    logic blank;
    ret   = 0;
    val   = '0;
    digit = (c >= ChrZero) && (c <= ChrNine);
    blank = c inside {ChrSpace, ChrTab, ChrNl, 8'h0B, 8'h0C, ChrCr};
    if (not_numeric || num_cnt >= 2) return 0;
    if (dstage == DsDigits) begin
      if (digit) begin
        num_val = 16'(num_val * 10 + (c - ChrZero));
        return 0;
      end
      val = num_neg ? -num_val : num_val;
      num_cnt++;
      dstage  = DsIdle;
      num_neg = 1'b0;
      num_val = '0;
      if (num_cnt == 2) return 2;
      first_num = val;
      ret = 1;
    end
    if (digit) begin
      num_val = 16'(c - ChrZero);
      dstage  = DsDigits;
    end else if (dstage == DsIdle && blank) begin
      ret = ret;
    end else if (dstage == DsIdle && (c == ChrPlus || c == ChrMinus)) begin
      num_neg = (c == ChrMinus);
      dstage  = DsSign;
    end else begin
      not_numeric = 1'b1;
    end
    return ret;
  endfunction

  task automatic decode_body(input logic [7:0] c);
    logic [15:0] v;
    logic        placed;
    placed = 1'b0;
    if (rel_mode) begin
      if (scan_number(c, v) == 2) begin
        place_cell(x_off + first_num, y_off + v);
        placed = 1'b1;
      end
    end
    if (c == ChrNl) begin
      row_cnt++;
      clear_line();
      phase = PhStart;
      return;
    end
    if (c == ChrStar) begin
      if (!placed && (!rel_mode || not_numeric)) place_cell(x_off + col_cnt, y_off + row_cnt);
      col_cnt++;
    end else if (c == ChrTab) begin
      col_cnt = 16'((col_cnt + TabStep) & ~(TabStep - 1));
    end else begin
      col_cnt++;
    end
  endtask

  task automatic decode_text_byte(input logic [7:0] c, input logic sof);
    int          r;
    logic [15:0] v;
    cells_from_byte = 0;
    byte_ignored    = 1'b0;
    if (sof) clear_parse();
    if (done) begin
      byte_ignored = 1'b1;
      return;
    end
    case (phase)
      PhStart: begin
        if (c == ChrHash) begin
          phase = PhHash;
        end else if (c == ChrNl) begin
          row_cnt++;
          clear_line();
        end else begin
          phase = PhBody;
          decode_body(c);
        end
      end
      PhBody: decode_body(c);
      PhHash: begin
        if (c == ChrNl) begin
          row_cnt++;
          clear_line();
          phase = PhStart;
        end else if (c == ChrE) begin
          done = 1'b1;
          push_result(KindEnd, '0, '0);
        end else if (c == ChrA) begin
          done = 1'b1;
          push_result(KindError, '0, '0);
        end else begin
          case (c)
            ChrB:    hdr = HdrB;
            ChrP:    hdr = HdrP;
            ChrR:    hdr = HdrR;
            default: hdr = HdrNone;
          endcase
          if (c == ChrP || c == ChrR) begin
            rel_mode = (c == ChrR);
            x_off    = '0;
            y_off    = '0;
            if (c == ChrP) row_cnt = '0;
          end
          phase = PhDirective;
        end
      end
      PhDirective: begin
        if (hdr == HdrP || hdr == HdrR) begin
          r = scan_number(c, v);
          if (r == 1) x_off = v;
          else if (r == 2) y_off = v;
        end
        if (c == ChrNl) begin
          if (hdr == HdrB) begin
            phase = PhSkipStart;
          end else begin
            row_cnt++;
            phase = PhStart;
          end
          hdr = HdrNone;
          clear_line();
        end
      end
      PhSkipStart: begin
        if (c == ChrHash) phase = PhSkipHash;
        else if (c != ChrNl) phase = PhSkipRest;
      end
      PhSkipHash: begin
        if (c == ChrE) phase = PhSkipClose;
        else if (c == ChrNl) phase = PhSkipStart;
        else phase = PhSkipRest;
      end
      PhSkipRest: begin
        if (c == ChrNl) phase = PhSkipStart;
      end
      PhSkipClose: begin
        if (c == ChrNl) begin
          row_cnt++;
          clear_line();
          phase = PhStart;
        end
      end
      default: phase = PhStart;
    endcase
  endtask

  // called at a falling edge, returns at a falling edge with tvalid still high
  task automatic send_text(input logic [7:0] c, input logic sof);
    int gap;
    if (burst_left == 0 && !gapless) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 200) : $urandom_range(1, 24);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= c;
    s_axis_tuser  <= sof;
    do @(posedge clk_i); while (!s_axis_tready);
    decode_text_byte(c, sof);
    if (!byte_ignored) bytes_decoded++;
    if (burst_left > 0) burst_left--;
    @(negedge clk_i);
  endtask

  task automatic go_idle();
    s_axis_tvalid <= 1'b0;
    while (expected_cells.size() != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  task automatic write_register(input cfg_idx_e idx, input logic [15:0] value);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    @(negedge clk_i);
    case (idx)
      RegHotX:  placement.hot_x  = value;
      RegHotY:  placement.hot_y  = value;
      RegMatXx: placement.mat_xx = value[1:0];
      RegMatXy: placement.mat_xy = value[1:0];
      RegMatYx: placement.mat_yx = value[1:0];
      RegMatYy: placement.mat_yy = value[1:0];
      default:  placement = placement;
    endcase
  endtask

  task automatic load_placement(input int setting);
    logic [15:0] hx;
    logic [15:0] hy;
    logic [1:0]  g [4];
    case (setting)
      0: begin
        hx = '0;
        hy = '0;
        foreach (g[k]) g[k] = GainNegTwo;
      end
      1: begin
        hx = 16'hFFFF;
        hy = 16'hFFFF;
        foreach (g[k]) g[k] = GainNeg;
      end
      default: begin
        case ($urandom_range(0, 3))
          0:       hx = '0;
          1:       hx = 16'hFFFF;
          default: hx = 16'($urandom_range(0, 65535));
        endcase
        hy = ($urandom_range(0, 3) == 0) ? 16'hFFFF : 16'($urandom_range(0, 65535));
        foreach (g[k]) g[k] = 2'($urandom_range(0, 3));
      end
    endcase
    write_register(RegHotX, hx);
    write_register(RegHotY, hy);
    write_register(RegMatXx, {14'd0, g[0]});
    write_register(RegMatXy, {14'd0, g[1]});
    write_register(RegMatYx, {14'd0, g[2]});
    write_register(RegMatYy, {14'd0, g[3]});
    cfg_we_i <= 1'b0;
  endtask

  task automatic put_text(input string s);
    for (int i = 0; i < s.len(); i++) file_text.push_back(s[i]);
  endtask

  task automatic put_blanks(input int lo, input int hi);
    repeat ($urandom_range(lo, hi)) file_text.push_back($urandom_range(0, 1) ? ChrSpace : ChrTab);
  endtask

  task automatic put_number();
    int digits;
    case ($urandom_range(0, 3))
      0:       file_text.push_back(ChrMinus);
      1:       file_text.push_back(ChrPlus);
      default: digits = 0;
    endcase
    digits = ($urandom_range(0, 7) == 0) ? $urandom_range(5, 8) : $urandom_range(1, 2);
    repeat (digits) file_text.push_back(ChrZero + 8'($urandom_range(0, 9)));
  endtask

  task automatic compose_file();
    int         lines;
    int         pick;
    logic [7:0] b;
    file_text.delete();
    lines = $urandom_range(2, 10);
    for (int l = 0; l < lines; l++) begin
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
        repeat ($urandom_range(0, 12)) begin
          case ($urandom_range(0, 7))
            0, 1, 2: file_text.push_back(ChrStar);
            3:       put_text(".");
            4:       file_text.push_back(ChrTab);
            5:       file_text.push_back(ChrSpace);
            6:       put_text("o");
            default: begin
              b = 8'($urandom_range(0, 255));
              file_text.push_back((b == ChrNl) ? ChrStar : b);
            end
          endcase
        end
      end else if (pick < 50) begin
        put_text($urandom_range(0, 1) ? "#P" : "#R");
        repeat ($urandom_range(0, 2)) begin
          put_blanks(1, 2);
          put_number();
        end
      end else if (pick < 70) begin
        put_blanks(0, 2);
        put_number();
        if ($urandom_range(0, 3) == 0) file_text.push_back(ChrMinus);
        else put_blanks(1, 2);
        put_number();
        case ($urandom_range(0, 3))
          0:       put_text("*");
          1:       put_blanks(1, 2);
          2:       put_text(" **");
          default: pick = pick;
        endcase
      end else if (pick < 78) begin
        put_text("#B");
        repeat ($urandom_range(0, 3)) begin
          file_text.push_back(ChrNl);
          case ($urandom_range(0, 2))
            0:       put_text("#C **");
            1:       put_text("**.*");
            default: put_text("#");
          endcase
        end
        file_text.push_back(ChrNl);
        put_text($urandom_range(0, 1) ? "#E" : "#E x");
      end else if (pick < 85) begin
        case ($urandom_range(0, 2))
          0:       put_text("#N name 1 2");
          1:       put_text("#C **");
          default: begin
            file_text.push_back(ChrHash);
            file_text.push_back(8'($urandom_range(8'h41, 8'h5A)));
          end
        endcase
      end else if (pick < 92) begin
        pick = pick;
      end else begin
        repeat ($urandom_range(1, 6)) file_text.push_back(8'($urandom_range(0, 255)));
      end
      file_text.push_back(ChrNl);
    end
    pick = $urandom_range(0, 99);
    if (pick < 80) begin
      put_text("#E");
      if ($urandom_range(0, 2) == 0) put_text("\n**");
    end else if (pick < 88) begin
      put_text("#A");
    end else if (pick < 94) begin
      put_text("#R\n5 -6");
    end else begin
      put_text("**.*");
    end
  endtask

  // receiver, with its own stall pattern and one long hold-off
  initial begin
    int mode;
    int seg;
    int tick;
    mode = 0;
    seg  = 0;
    tick = 0;
    m_axis_tready = 1'b0;
    pressure_done = 1'b0;
    forever begin
      @(negedge clk_i);
      if (pressure_go && !pressure_done) begin
        m_axis_tready <= 1'b0;
        repeat (HoldCycles) @(negedge clk_i);
        pressure_done = 1'b1;
      end
      if (seg == 0) begin
        mode = $urandom_range(0, 3);
        seg  = $urandom_range(20, 200);
      end
      seg--;
      tick++;
      case (mode)
        0:       m_axis_tready <= 1'b1;
        1:       m_axis_tready <= 1'($urandom_range(0, 1));
        2:       m_axis_tready <= ((tick % 4) == 0);
        default: m_axis_tready <= ($urandom_range(0, 7) != 0);
      endcase
    end
  end

  function automatic void report_mismatch(input string what, input cell_result_t want,
                                          input cell_result_t got);
    mismatches++;
    if (mismatches <= MaxReported)
      $display("mismatch (%s): expected kind %0d x %0d y %0d, got kind %0d x %0d y %0d",
               what, want.kind, want.x, want.y, got.kind, got.x, got.y);
  endfunction

  always @(posedge clk_i) begin
    cell_result_t want;
    cell_result_t got;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = '{kind_e'(m_axis_tuser), m_axis_tdata[CellW-1:0], m_axis_tdata[2*CellW-1:CellW]};
      if (expected_cells.size() == 0) begin
        report_mismatch("unexpected result", '0, got);
      end else begin
        want = expected_cells.pop_front();
        if (got.kind !== want.kind || got.x !== want.x || got.y !== want.y)
          report_mismatch("wrong field", want, got);
      end
    end
  end

  initial begin
    int setting;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = '0;
    cfg_data_i    = '0;
    rst_ni        = 1'b0;
    cycle_count   = 0;
    mismatches    = 0;
    burst_left    = 0;
    gapless       = 1'b0;
    pressure_go   = 1'b0;
    bytes_decoded = 0;
    placement     = CfgReset;
    clear_parse();
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed rows, default placement after reset
    for (int i = 0; i < $size(DirectedRows); i++) begin
      send_text(DirectedRows[i].text, DirectedRows[i].sof);
      if (DirectedRows[i].typed) begin
        repeat (cells_from_byte) void'(expected_cells.pop_back());
        expected_cells.push_back('{DirectedRows[i].kind, DirectedRows[i].x, DirectedRows[i].y});
      end
    end
    go_idle();

    // long receiver hold-off while a row of cells keeps coming
    gapless = 1'b1;
    send_text(ChrStar, 1'b1);
    pressure_go = 1'b1;
    repeat (40) send_text(ChrStar, 1'b0);
    gapless = 1'b0;
    go_idle();

    setting = 0;
    bytes_decoded = 0;
    while (bytes_decoded < RandomBytes) begin
      if (setting < 2 || $urandom_range(0, 2) == 0) begin
        go_idle();
        load_placement(setting);
        setting++;
      end
      compose_file();
      foreach (file_text[i]) send_text(file_text[i], i == 0);
    end
    go_idle();

    if (expected_cells.size() != 0) begin
      $display("%0d expected results never arrived", expected_cells.size());
      mismatches += expected_cells.size();
    end
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
